// ----- design/wss_pkg.sv -----
// wss_pkg: sizes, mode codes and sequencer states for the window statistic selector.
// No dependencies.
`timescale 1ns / 1ps
package wss_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int SMP_W       = 16;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = SMP_W + IDX_W;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int MODE_W      = 3;

  localparam logic [MODE_W-1:0] MODE_MEAN   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MEDIAN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIN    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MAX    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LAST   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DEV    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DEV_LD,
    ST_DEV,
    ST_RANK_LD,
    ST_RANK_CV,
    ST_RANK_SCAN,
    ST_OUT
  } wss_state_e;

endpackage

// ----- design/window_statistic_selector.sv -----
// Window statistic selector. A sample beat without last is taken while busy stays low.
// A closing beat raises busy; done_o strobes for one cycle: last sample directly, mean by
// the divider, peak deviation by divider then scan, median/min/max by the rank search.
// The divider runs one quotient bit a cycle; rank search and deviation scan use one
// store read port a cycle. rst_ni (async, active low) empties the window, sets mode 0.
// The receiver cannot stall: done_o and statistic_o are valid for exactly one cycle.
`timescale 1ns / 1ps
module window_statistic_selector
  import wss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [SMP_W-1:0]  sample_i,
  input  logic              last_i,
  input  logic              mode_we_i,
  input  logic [MODE_W-1:0] mode_wdata_i,
  output logic              done_o,
  output logic [SMP_W-1:0]  statistic_o
);

  logic [SMP_W-1:0] mem_q [MAX_SAMPLES];
  logic [SMP_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;

  wss_state_e        state_q, state_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SMP_W-1:0]  last_q, last_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [IDX_W-1:0]  j_q, j_d;
  logic [IDX_W-1:0]  ci_q, ci_d;
  logic [SMP_W-1:0]  cv_q, cv_d;
  logic [CNT_W-1:0]  rank_q, rank_d;
  logic [SMP_W-1:0]  best_q, best_d;
  logic [SMP_W-1:0]  pick_q, pick_d;
  logic [SMP_W-1:0]  res_q, res_d;

  logic [CNT_W:0]    trial, diff;
  logic              div_ge;
  logic [SUM_W-1:0]  quo_nxt;
  logic              hit;
  logic [CNT_W-1:0]  rank_nxt, k_sel;
  logic [SMP_W-1:0]  mean, gap;
  logic              scan_end, full, better;

  always_comb begin
    // restoring divide, one quotient bit a cycle
    trial    = {rem_q, quo_q[SUM_W-1]};
    diff     = trial - {1'b0, cnt_q};
    div_ge   = (trial >= {1'b0, cnt_q});
    quo_nxt  = {quo_q[SUM_W-2:0], div_ge};
    mean     = quo_q[SMP_W-1:0];
    gap      = (rd_q > mean) ? (rd_q - mean) : (mean - rd_q);
    better   = (gap > best_q);
    // ties broken by index so every rank is unique
    hit      = (rd_q < cv_q) || ((rd_q == cv_q) && (j_q < ci_q));
    rank_nxt = rank_q + CNT_W'(hit);
    scan_end = ({1'b0, j_q} == (cnt_q - CNT_W'(1)));
    full     = (cnt_q == CNT_W'(MAX_SAMPLES));
    unique case (mode_q)
      MODE_MEDIAN: k_sel = cnt_q >> 1;
      MODE_MIN:    k_sel = '0;
      default:     k_sel = cnt_q - CNT_W'(1);
    endcase
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    last_d  = last_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    step_d  = step_q;
    j_d     = j_q;
    ci_d    = ci_q;
    cv_d    = cv_q;
    rank_d  = rank_q;
    best_d  = best_q;
    pick_d  = pick_q;
    res_d   = res_q;
    rd_addr = j_q;
    wr_en   = 1'b0;
    if (mode_we_i) begin
      mode_d = mode_wdata_i;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (!full) begin
            wr_en  = 1'b1;
            cnt_d  = cnt_q + CNT_W'(1);
            sum_d  = sum_q + SUM_W'(sample_i);
            last_d = sample_i;
          end
          if (last_i) begin
            quo_d  = sum_d;
            rem_d  = '0;
            step_d = '0;
            ci_d   = '0;
            unique case (mode_q)
              MODE_MEDIAN, MODE_MIN, MODE_MAX: state_d = ST_RANK_LD;
              MODE_LAST: begin
                res_d   = last_d;
                state_d = ST_OUT;
              end
              default: state_d = ST_DIV;
            endcase
          end
        end
      end
      ST_DIV: begin
        rem_d  = div_ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_d  = quo_nxt;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) begin
          if (mode_q == MODE_DEV) begin
            state_d = ST_DEV_LD;
          end else begin
            res_d   = quo_nxt[SMP_W-1:0];
            state_d = ST_OUT;
          end
        end
      end
      ST_DEV_LD: begin
        rd_addr = '0;
        j_d     = '0;
        best_d  = '0;
        pick_d  = '0;
        state_d = ST_DEV;
      end
      ST_DEV: begin
        rd_addr = j_q + IDX_W'(1);
        if (better) begin
          best_d = gap;
          pick_d = rd_q;
        end
        if (scan_end) begin
          res_d   = better ? rd_q : pick_q;
          state_d = ST_OUT;
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_RANK_LD: begin
        rd_addr = ci_q;
        state_d = ST_RANK_CV;
      end
      ST_RANK_CV: begin
        cv_d    = rd_q;
        j_d     = '0;
        rank_d  = '0;
        rd_addr = '0;
        state_d = ST_RANK_SCAN;
      end
      ST_RANK_SCAN: begin
        rd_addr = j_q + IDX_W'(1);
        rank_d  = rank_nxt;
        if (scan_end) begin
          if (rank_nxt == k_sel) begin
            res_d   = cv_q;
            state_d = ST_OUT;
          end else begin
            ci_d    = ci_q + IDX_W'(1);
            state_d = ST_RANK_LD;
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_OUT: begin
        cnt_d   = '0;
        sum_d   = '0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_MEAN;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    j_q    <= j_d;
    ci_q   <= ci_d;
    cv_q   <= cv_d;
    rank_q <= rank_d;
    best_q <= best_d;
    pick_q <= pick_d;
    res_q  <= res_d;
  end

  // window store: one write, one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IDX_W-1:0]] <= sample_i;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = (state_q == ST_OUT);
  assign statistic_o = res_q;

endmodule

// ----- design/wss_checker.sv -----
// wss_checker: port-level assertions for the window statistic selector, bound to that module.
// Depends on wss_pkg.
`timescale 1ns / 1ps
module wss_checker
  import wss_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [SMP_W-1:0]  sample_i,
  input logic              last_i,
  input logic              mode_we_i,
  input logic [MODE_W-1:0] mode_wdata_i,
  input logic              done_o,
  input logic [SMP_W-1:0]  statistic_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done without busy");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o) else $error("busy held after result beat");

  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> busy) else $error("closing beat did not start work");

  a_open_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_i) |=> !busy && !done_o) else $error("open beat caused work");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && last_i)) else $error("busy without closing beat");

endmodule

bind window_statistic_selector wss_checker u_wss_checker (.*);

// ----- test/tb_top.sv -----
// Self-checking bench for window_statistic_selector: windows of samples with random gaps,
// every mode code, full windows; a scoreboard predicts each statistic. Needs wss_pkg.
`timescale 1ns / 1ps
module tb_top;
  import wss_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 320;
  localparam int PHASE_BEATS    = 350;
  localparam int REPORT_MAX     = 10;

  class window_scoreboard;
    logic [SMP_W-1:0] store [MAX_SAMPLES];
    int unsigned      fill = 0;
    logic [SUM_W-1:0] total = '0;
    logic [MODE_W-1:0] mode = MODE_MEAN;
    logic [SMP_W-1:0] expected_stats [$];
    int unsigned      errors = 0;

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("%0t: %s", $time, msg);
    endfunction

    function logic [SMP_W-1:0] window_statistic();
      logic [SMP_W-1:0] sorted [MAX_SAMPLES];
      logic [SMP_W-1:0] v, avg, pick, gap, best;
      int unsigned j;
      avg = SMP_W'(total / fill);
      for (int i = 0; i < fill; i++) begin
        v = store[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      case (mode)
        MODE_MEDIAN: return sorted[fill/2];
        MODE_MIN:    return sorted[0];
        MODE_MAX:    return sorted[fill-1];
        MODE_LAST:   return store[fill-1];
        MODE_DEV: begin
          best = '0;
          pick = '0;
          // first sample strictly furthest from the floored mean wins
          for (int i = 0; i < fill; i++) begin
            gap = (store[i] > avg) ? store[i] - avg : avg - store[i];
            if (gap > best) begin
              best = gap;
              pick = store[i];
            end
          end
          return pick;
        end
        default:     return avg;
      endcase
    endfunction

    function void note_beat(logic [SMP_W-1:0] value, logic closing);
      if (fill < MAX_SAMPLES) begin
        store[fill] = value;
        fill++;
        total += value;
      end
      if (closing) begin
        expected_stats.push_back(window_statistic());
        fill = 0;
        total = '0;
      end
    endfunction

    function void check_result(logic [SMP_W-1:0] got);
      logic [SMP_W-1:0] want;
      if (expected_stats.size() == 0) begin
        flag($sformatf("unexpected statistic %h", got));
        return;
      end
      want = expected_stats.pop_front();
      if (got !== want)
        flag($sformatf("statistic mismatch: expected %h got %h", want, got));
    endfunction

    function void close_out();
      if (expected_stats.size() != 0)
        flag($sformatf("%0d statistics never arrived", expected_stats.size()));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [SMP_W-1:0]  sample_i = '0;
  logic              last_i = 1'b0;
  logic              mode_we_i = 1'b0;
  logic [MODE_W-1:0] mode_wdata_i = '0;
  logic              done_o;
  logic [SMP_W-1:0]  statistic_o;

  window_scoreboard sb = new;
  int unsigned sender_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  window_statistic_selector uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .sample_i     (sample_i),
    .last_i       (last_i),
    .mode_we_i    (mode_we_i),
    .mode_wdata_i (mode_wdata_i),
    .done_o       (done_o),
    .statistic_o  (statistic_o)
  );

  always #10 clk_i = ~clk_i;

  // monitor and watchdog: results are checked before the beat of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(statistic_o);
      if (start && !busy) sb.note_beat(sample_i, last_i);
      if (done_o || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [SMP_W-1:0] value, input logic closing);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    sample_i <= value;
    last_i   <= closing;
    do @(posedge clk_i); while (busy);
  endtask

  // hold off until every statistic is back and the block has settled
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.expected_stats.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] code);
    drain();
    mode_we_i    <= 1'b1;
    mode_wdata_i <= code;
    @(posedge clk_i);
    mode_we_i <= 1'b0;
    sb.mode = code;
  endtask

  task automatic send_window(input int unsigned len);
    int unsigned flavour;
    logic [SMP_W-1:0] base, value;
    flavour = $urandom_range(7);
    base    = SMP_W'($urandom);
    for (int i = 0; i < len; i++) begin
      case (flavour)
        4, 5:    value = base + SMP_W'($urandom_range(3)); // ties for median/deviation
        6:       value = $urandom_range(1) ? '1 : '0;
        7:       value = base;
        default: value = SMP_W'($urandom);
      endcase
      send_beat(value, i == len - 1);
    end
  endtask

  initial begin
    logic [MODE_W-1:0] mode_cycle [8];
    int unsigned idle_profile [3];
    int unsigned sent, seg, len;
    mode_cycle = '{MODE_MEAN, MODE_MEDIAN, MODE_MIN, MODE_MAX, MODE_LAST, MODE_DEV,
                   MODE_SPARE_LO, MODE_SPARE_HI};
    idle_profile = '{15, 46, 0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed windows
    write_mode(MODE_MEAN);
    send_beat(16'h0000, 1'b1);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h0001, 1'b1);
    write_mode(MODE_MEDIAN);
    send_beat(16'h0005, 1'b0);
    send_beat(16'h0001, 1'b0);
    send_beat(16'h0009, 1'b0);
    send_beat(16'h0003, 1'b1);
    write_mode(MODE_MIN);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h0000, 1'b1);
    write_mode(MODE_MAX);
    send_beat(16'h0007, 1'b0);
    send_beat(16'hFFFF, 1'b1);
    write_mode(MODE_LAST);
    send_beat(16'h0001, 1'b0);
    send_beat(16'h0002, 1'b0);
    send_beat(16'hAAAA, 1'b1);
    write_mode(MODE_DEV);
    send_beat(16'h0010, 1'b0);   // flat window gives zero
    send_beat(16'h0010, 1'b0);
    send_beat(16'h0010, 1'b1);
    send_beat(16'h0000, 1'b0);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h8000, 1'b1);
    write_mode(MODE_SPARE_HI);
    send_beat(16'h0004, 1'b0);
    send_beat(16'h0006, 1'b1);
    write_mode(MODE_SPARE_LO);
    send_beat(16'h0003, 1'b1);

    // random windows; the occasional long one overruns the store
    seg = 0;
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_profile[phase];
      sent = 0;
      while (sent < PHASE_BEATS) begin
        write_mode(mode_cycle[seg % 8]);
        seg++;
        repeat (6) begin
          if ($urandom_range(11) == 0) drain();
          len = ($urandom_range(9) == 0) ? $urandom_range(24, 17) : $urandom_range(16, 1);
          send_window(len);
          sent += len;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.close_out();
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
design/wss_pkg.sv
design/window_statistic_selector.sv
design/wss_checker.sv
test/tb_top.sv
